// ===== src/assert_macros.svh =====
// assertion macros shared by the timebase drift calibrator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// property whose consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/tdc_pkg.sv =====
// package with widths, constants, state codes and control structs of the calibrator
`default_nettype none

package tdc_pkg;

	localparam int TIME_W  = 63;
	localparam int RATE_W  = 34;
	localparam int REF_W   = 32;
	localparam int HELD_W  = 4;
	localparam int MUL_W   = 30;
	localparam int NUM_W   = TIME_W + MUL_W;
	localparam int DEN_W   = RATE_W;
	localparam int EST_W   = 41;
	localparam int DEV10_W = EST_W + 3;
	localparam int CNT_W   = 7;

	localparam logic [TIME_W-1:0] TIME_MAX    = {TIME_W{1'b1}};
	localparam logic [RATE_W-1:0] RATE_MAX    = {RATE_W{1'b1}};
	localparam logic [RATE_W-1:0] NOM_RESET   = RATE_W'(1000);
	localparam logic [MUL_W-1:0]  NS_PER_S    = MUL_W'(1000000000);
	localparam logic [EST_W-1:0]  EST_CAP     = {1'b1, {(EST_W-1){1'b0}}};

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_TIME,
		ST_EST,
		ST_DEV,
		ST_TEST,
		ST_UPD,
		ST_MEAN,
		ST_REJ,
		ST_OUT
	} state_t;

	// which quotient the shared divider is producing
	typedef enum logic [1:0] {
		PH_TIME,
		PH_EST,
		PH_MEAN
	} phase_t;

	typedef struct packed {
		logic   load_item;
		logic   mul_load_ref;
		logic   mul_step;
		logic   div_load;
		phase_t div_sel;
		logic   div_step;
		logic   take_time;
		logic   take_est;
		logic   take_dev;
		logic   take_test;
		logic   ring_upd;
		logic   take_mean;
		logic   ring_clear;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic is_read;
		logic chk;
		logic ok;
	} stat_t;

endpackage

`default_nettype wire

// ===== src/timebase_drift_calibrator.sv =====
// A read word, once accepted, runs a shift-add multiply by 1e9 and a restoring divide
// by the rate, then the time update and the result load.
// A calibrate word adds a second multiply and divide for the estimate and, when the
// estimate enters the ring, a third divide for the mean.
// One word at a time; the result load waits while the output is stalled.
// Reset (arst_n low) clears anchors, ring bookkeeping and sets the nominal rate to 1000.
`default_nettype none

module timebase_drift_calibrator
	import tdc_pkg::*;
#(
	parameter int RING_DEPTH  = 8,
	parameter int REF_RATE_HZ = 1000
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [RATE_W-1:0] cfg_wdata,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	// tick_count[62:0], ref_millis[94:63], zero pad [95]
	input  wire logic [95:0]       s_tdata,
	// kind
	input  wire logic              s_tuser,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	// time_ns[62:0], freq_in_use[96:63], sample_accepted[97], samples_held[101:98],
	// zero pad [103:102]
	output logic      [103:0]      m_tdata
);

	cmd_t              cmd;
	stat_t             stat;
	logic [TIME_W-1:0] out_time_ns;
	logic [RATE_W-1:0] out_freq;
	logic              out_accepted;
	logic [HELD_W-1:0] out_held;

	tdc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	tdc_dp #(
		.RING_DEPTH  (RING_DEPTH),
		.REF_RATE_HZ (REF_RATE_HZ)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_kind      (s_tuser),
		.in_ticks     (s_tdata[TIME_W-1:0]),
		.in_ref       (s_tdata[TIME_W+REF_W-1:TIME_W]),
		.cmd          (cmd),
		.stat         (stat),
		.out_time_ns  (out_time_ns),
		.out_freq     (out_freq),
		.out_accepted (out_accepted),
		.out_held     (out_held)
	);

	// pack the result word
	assign m_tdata = {2'b00, out_held, out_accepted, out_freq, out_time_ns};

endmodule

`default_nettype wire

// ===== src/tdc_div.sv =====
// restoring divider, one quotient bit per step
`default_nettype none

module tdc_div
	import tdc_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             load,
	input  wire logic             step,
	input  wire logic [NUM_W-1:0] num_in,
	input  wire logic [DEN_W-1:0] den_in,
	output logic      [NUM_W-1:0] quot
);

	logic [NUM_W-1:0] num_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	// shift in the next dividend bit and try the subtraction
	always_comb begin
		trial = {rem_q, num_q[NUM_W-1]};
		ge    = trial >= {1'b0, den_q};
	end

	// dividend shifts out at the top while quotient bits enter at the bottom
	always_ff @(posedge clk) begin
		if (load) begin
			num_q <= num_in;
			den_q <= den_in;
			rem_q <= '0;
		end else if (step) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], ge};
		end
	end

	assign quot = num_q;

endmodule

`default_nettype wire

// ===== src/tdc_ctrl.sv =====
// controller state machine sequencing multiply, divide and ring update steps
`default_nettype none

module tdc_ctrl
	import tdc_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  wire logic  m_tready,
	input  wire stat_t stat,
	output cmd_t       cmd
);

	`include "assert_macros.svh"

	state_t             state_q, state_n;
	phase_t             phase_q, phase_n;
	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic               m_tvalid_q;

	// state, pass and step counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= PH_TIME;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			phase_q <= phase_n;
			cnt_q   <= cnt_n;
		end
	end

	// output word valid, set on load and cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;

	// next state and commands
	always_comb begin
		state_n  = state_q;
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		cmd      = '0;
		cmd.div_sel = phase_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_item = 1'b1;
					phase_n       = PH_TIME;
					cnt_n         = '0;
					state_n       = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				if (cnt_q == CNT_W'(MUL_W - 1)) begin
					cnt_n   = '0;
					state_n = ST_DLOAD;
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			ST_DLOAD: begin
				cmd.div_load = 1'b1;
				state_n      = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CNT_W'(NUM_W - 1)) begin
					cnt_n = '0;
					unique case (phase_q)
						PH_TIME: state_n = ST_TIME;
						PH_EST:  state_n = ST_EST;
						PH_MEAN: state_n = ST_MEAN;
						default: state_n = ST_IDLE;
					endcase
				end else begin
					cnt_n = cnt_q + 1'b1;
				end
			end
			ST_TIME: begin
				cmd.take_time = 1'b1;
				priority if (stat.is_read) begin
					state_n = ST_OUT;
				end else if (stat.chk) begin
					cmd.mul_load_ref = 1'b1;
					phase_n          = PH_EST;
					state_n          = ST_MUL;
				end else begin
					state_n = ST_REJ;
				end
			end
			ST_EST: begin
				cmd.take_est = 1'b1;
				state_n      = ST_DEV;
			end
			ST_DEV: begin
				cmd.take_dev = 1'b1;
				state_n      = ST_TEST;
			end
			ST_TEST: begin
				cmd.take_test = 1'b1;
				state_n       = stat.ok ? ST_UPD : ST_REJ;
			end
			ST_UPD: begin
				cmd.ring_upd = 1'b1;
				phase_n      = PH_MEAN;
				state_n      = ST_DLOAD;
			end
			ST_MEAN: begin
				cmd.take_mean = 1'b1;
				state_n       = ST_OUT;
			end
			ST_REJ: begin
				cmd.ring_clear = 1'b1;
				state_n        = ST_OUT;
			end
			ST_OUT: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_n      = ST_IDLE;
				end
			end
			default: begin
				state_n = ST_IDLE;
			end
		endcase
	end

	`ASSERT_NEXT(a_accept_starts_mul, s_tvalid && s_tready, state_q == ST_MUL, "accepted word did not start the multiply")
	`ASSERT_ALWAYS(a_div_cnt_bound, (state_q != ST_DIV) || (cnt_q < CNT_W'(NUM_W)), "divide step count overran")
	`ASSERT_NEXT(a_out_load_valid, cmd.out_load, m_tvalid_q && (state_q == ST_IDLE), "result load did not raise valid")

endmodule

`default_nettype wire

// ===== src/tdc_dp.sv =====
// datapath: time anchor, shift-add multiplier, estimate check and averaging ring
`default_nettype none

module tdc_dp
	import tdc_pkg::*;
#(
	parameter int RING_DEPTH  = 8,
	parameter int REF_RATE_HZ = 1000
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [RATE_W-1:0] cfg_wdata,
	input  wire logic              in_kind,
	input  wire logic [TIME_W-1:0] in_ticks,
	input  wire logic [REF_W-1:0]  in_ref,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	output logic      [TIME_W-1:0] out_time_ns,
	output logic      [RATE_W-1:0] out_freq,
	output logic                   out_accepted,
	output logic      [HELD_W-1:0] out_held
);

	`include "assert_macros.svh"

	localparam int HEAD_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
	localparam int FILL_W = $clog2(RING_DEPTH + 1);
	localparam int SUM_W  = RATE_W + $clog2(RING_DEPTH);
	localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_DEPTH - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(RING_DEPTH);
	localparam logic [MUL_W-1:0]  REF_MUL   = MUL_W'(REF_RATE_HZ);

	// persistent state
	logic [RATE_W-1:0] nom_q;
	logic [TIME_W-1:0] anchor_ticks_q;
	logic [TIME_W-1:0] anchor_time_q;
	logic [RATE_W-1:0] rate_now_q;
	logic [REF_W-1:0]  last_ref_q;
	logic              ref_seen_q;
	logic [HEAD_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q;
	logic [SUM_W-1:0]  sum_q;
	logic              ok_q;

	// per-word working registers
	logic              kind_q;
	logic              chk_q;
	logic [TIME_W-1:0] ticks_q;
	logic [TIME_W-1:0] dticks_q;
	logic [REF_W-1:0]  ref_q;
	logic [REF_W-1:0]  dms_q;
	logic [TIME_W-1:0] time_q;
	logic [EST_W-1:0]  est_q;
	logic [EST_W-1:0]  dev_q;
	logic [NUM_W-1:0]  acc_q;
	logic [NUM_W-1:0]  mc_q;
	logic [MUL_W-1:0]  mp_q;

	// averaging ring memory
	logic [RATE_W-1:0] ring_mem [RING_DEPTH];
	logic [RATE_W-1:0] ring_rd_q;

	logic [RATE_W-1:0] nom_eff;
	logic [RATE_W-1:0] rate_eff;
	logic [TIME_W-1:0] dticks_c;
	logic [NUM_W-1:0]  div_num;
	logic [DEN_W-1:0]  div_den;
	logic [NUM_W-1:0]  quot;
	logic [TIME_W-1:0] scaled;
	logic [TIME_W:0]   tsum;
	logic [TIME_W-1:0] t_c;
	logic [EST_W-1:0]  nom_ext;
	logic [DEV10_W-1:0] dev10;
	logic              ok_c;
	logic [RATE_W-1:0] est_c;
	logic              full;
	logic [SUM_W-1:0]  drop;

	// effective rates, zero nominal counts as one hertz
	always_comb begin
		nom_eff  = (nom_q == '0) ? RATE_W'(1) : nom_q;
		rate_eff = (rate_now_q == '0) ? nom_eff : rate_now_q;
		dticks_c = in_ticks - anchor_ticks_q;
	end

	// divider operand selection
	always_comb begin
		unique case (cmd.div_sel)
			PH_TIME: begin
				div_num = acc_q;
				div_den = rate_eff;
			end
			PH_EST: begin
				div_num = acc_q;
				div_den = DEN_W'(dms_q);
			end
			PH_MEAN: begin
				div_num = NUM_W'(sum_q);
				div_den = DEN_W'(fill_q);
			end
			default: begin
				div_num = acc_q;
				div_den = rate_eff;
			end
		endcase
	end

	tdc_div u_div (
		.clk    (clk),
		.load   (cmd.div_load),
		.step   (cmd.div_step),
		.num_in (div_num),
		.den_in (div_den),
		.quot   (quot)
	);

	// scaled time saturated and added to the anchor
	always_comb begin
		scaled = (|quot[NUM_W-1:TIME_W]) ? TIME_MAX : quot[TIME_W-1:0];
		tsum   = {1'b0, anchor_time_q} + {1'b0, scaled};
		t_c    = (tsum > {1'b0, TIME_MAX}) ? TIME_MAX : tsum[TIME_W-1:0];
	end

	// acceptance window test and ring entry value
	always_comb begin
		nom_ext = EST_W'(nom_eff);
		dev10   = {dev_q, 3'b000} + {2'b00, dev_q, 1'b0};
		ok_c    = dev10 < DEV10_W'(nom_eff);
		est_c   = (est_q > EST_W'(RATE_MAX)) ? RATE_MAX : est_q[RATE_W-1:0];
		full    = fill_q >= FILL_FULL;
		drop    = full ? SUM_W'(ring_rd_q) : '0;
	end

	assign stat.is_read = kind_q;
	assign stat.chk     = chk_q;
	assign stat.ok      = ok_c;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nom_q <= NOM_RESET;
		end else if (cfg_we) begin
			nom_q <= cfg_wdata;
		end
	end

	// anchor, reference and ring bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			anchor_ticks_q <= '0;
			anchor_time_q  <= '0;
			rate_now_q     <= '0;
			last_ref_q     <= '0;
			ref_seen_q     <= 1'b0;
			head_q         <= '0;
			fill_q         <= '0;
			sum_q          <= '0;
			ok_q           <= 1'b0;
		end else begin
			if (cmd.load_item) begin
				ok_q <= 1'b0;
			end
			if (cmd.take_time && !kind_q) begin
				anchor_time_q  <= t_c;
				anchor_ticks_q <= ticks_q;
				last_ref_q     <= ref_q;
				ref_seen_q     <= 1'b1;
			end
			if (cmd.take_test) begin
				ok_q <= ok_c;
			end
			if (cmd.ring_upd) begin
				sum_q  <= sum_q - drop + SUM_W'(est_c);
				head_q <= (head_q == HEAD_LAST) ? '0 : head_q + 1'b1;
				if (!full) begin
					fill_q <= fill_q + 1'b1;
				end
			end
			if (cmd.take_mean) begin
				rate_now_q <= quot[RATE_W-1:0];
			end
			if (cmd.ring_clear) begin
				head_q     <= '0;
				fill_q     <= '0;
				sum_q      <= '0;
				rate_now_q <= '0;
			end
		end
	end

	// word capture, shift-add multiply and intermediate results
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			kind_q   <= in_kind;
			ticks_q  <= in_ticks;
			dticks_q <= dticks_c;
			ref_q    <= in_ref;
			dms_q    <= in_ref - last_ref_q;
			chk_q    <= ref_seen_q && (in_ref != last_ref_q);
			acc_q    <= '0;
			mc_q     <= NUM_W'(dticks_c);
			mp_q     <= NS_PER_S;
		end else if (cmd.mul_load_ref) begin
			acc_q <= '0;
			mc_q  <= NUM_W'(dticks_q);
			mp_q  <= REF_MUL;
		end else if (cmd.mul_step) begin
			if (mp_q[0]) begin
				acc_q <= acc_q + mc_q;
			end
			mc_q <= {mc_q[NUM_W-2:0], 1'b0};
			mp_q <= {1'b0, mp_q[MUL_W-1:1]};
		end
		if (cmd.take_time) begin
			time_q <= t_c;
		end
		if (cmd.take_est) begin
			est_q <= (quot > NUM_W'(EST_CAP)) ? EST_CAP : quot[EST_W-1:0];
		end
		if (cmd.take_dev) begin
			dev_q <= (est_q > nom_ext) ? est_q - nom_ext : nom_ext - est_q;
		end
	end

	// ring memory, registered read of the entry at the head
	always_ff @(posedge clk) begin
		if (cmd.take_test) begin
			ring_rd_q <= ring_mem[head_q];
		end
		if (cmd.ring_upd) begin
			ring_mem[head_q] <= est_c;
		end
	end

	// result word register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_time_ns  <= time_q;
			out_freq     <= rate_eff;
			out_accepted <= !kind_q && ok_q;
			out_held     <= HELD_W'(fill_q);
		end
	end

	`ASSERT_ALWAYS(a_fill_bound, fill_q <= FILL_FULL, "ring fill count exceeds depth")
	`ASSERT_ALWAYS(a_rate_has_fill, (rate_now_q == '0) || (fill_q != '0), "averaged rate set with empty ring")
	`ASSERT_NEXT(a_clear_empties, cmd.ring_clear, (fill_q == '0) && (rate_now_q == '0), "ring clear left state behind")

endmodule

`default_nettype wire
